// ===== src/assert_macros.svh =====
// assertion macros shared by the placement table rtl
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked property, disabled while reset is high
`define GRPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also covers the reset behavior itself
`define GRPT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GRPT_ASSERT(label, prop, msg)

`define GRPT_ASSERT_RST(label, prop, msg)

`endif

`endif

// ===== src/grpt_pkg.sv =====
// shared types and codes for the grid rectangle placement table
// no dependencies
package grpt_pkg;

  // operation codes
  localparam logic [1:0] OP_ADD        = 2'd0;
  localparam logic [1:0] OP_REMOVE     = 2'd1;
  localparam logic [1:0] OP_FIND_POINT = 2'd2;
  localparam logic [1:0] OP_FIND_ID    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERLAP   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // request word
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] item_id;
    logic [11:0] pos_col;
    logic [11:0] pos_row;
    logic [12:0] span_cols;
    logic [12:0] span_rows;
  } req_t;

  // response word
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] found_id;
    logic [11:0] found_col;
    logic [11:0] found_row;
    logic [12:0] found_span_cols;
    logic [12:0] found_span_rows;
  } rsp_t;

  // one stored table entry
  typedef struct packed {
    logic [15:0] id;
    logic [11:0] row;
    logic [11:0] col;
    logic [12:0] span_rows;
    logic [12:0] span_cols;
  } entry_t;

  // compare results for one entry against the pending request
  typedef struct packed {
    logic overlap;
    logic cell_hit;
    logic id_eq;
  } match_t;

endpackage

// ===== src/grpt_chan_if.sv =====
// valid/ready channel carrying one word of a given type
// depends on nothing; word types come from grpt_pkg at the instance
interface grpt_chan_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/grid_rectangle_placement_table.sv =====
// Grid rectangle placement table, top level.
// Depends on grpt_pkg, grpt_chan_if, grpt_ram and grpt_ctrl.
//
// Usage:
//   req carries one command word (op, item_id, pos_col, pos_row, span_cols,
//   span_rows); rsp returns exactly one response word per command (status,
//   slot and the found entry fields). Both are valid/ready channels; a word
//   moves on a rising edge where valid and ready are both high.
//   Entries live in one ram of MAX_ENTRIES words with a registered read. A
//   command scans the stored entries one per cycle from slot zero; remove
//   then shifts the later entries down one slot, one read and one write per
//   cycle, continuing the same address sweep.
//   A command on an empty table skips the scan, and a find stops scanning at
//   its first hit. The response is loaded into the output register once the
//   command completes, after its scan and any shift.
//   Commands are handled one at a time: req.ready is high only while the
//   sequencer is idle. The response sits in an output register, so the next
//   command is taken while an earlier response waits; if rsp stalls, the
//   following command finishes its scan and then holds until the register frees.
//   Reset (synchronous, active high) empties the table and drops any response;
//   no clearing pass is needed.
module grid_rectangle_placement_table import grpt_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  grpt_chan_if.sink   req,
  grpt_chan_if.source rsp
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = $bits(entry_t);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // entry storage
  grpt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // command sequencer
  grpt_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ===== src/grpt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module grpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/grpt_match.sv =====
// compares one stored entry against the pending request
// depends on grpt_pkg
module grpt_match import grpt_pkg::*; (
  input  req_t   cmd,
  input  entry_t ent,
  output match_t hits
);

  logic [13:0] ent_col_end;
  logic [13:0] ent_row_end;
  logic [13:0] cmd_col_end;
  logic [13:0] cmd_row_end;

  // exclusive end coordinates, wide enough to never wrap
  assign ent_col_end = 14'(ent.col) + 14'(ent.span_cols);
  assign ent_row_end = 14'(ent.row) + 14'(ent.span_rows);
  assign cmd_col_end = 14'(cmd.pos_col) + 14'(cmd.span_cols);
  assign cmd_row_end = 14'(cmd.pos_row) + 14'(cmd.span_rows);

  // rectangles overlap when both axis ranges meet
  assign hits.overlap = (14'(ent.col) < cmd_col_end) && (14'(cmd.pos_col) < ent_col_end) &&
                        (14'(ent.row) < cmd_row_end) && (14'(cmd.pos_row) < ent_row_end);

  // query cell lies within the entry
  assign hits.cell_hit = (cmd.pos_col >= ent.col) && (14'(cmd.pos_col) < ent_col_end) &&
                         (cmd.pos_row >= ent.row) && (14'(cmd.pos_row) < ent_row_end);

  assign hits.id_eq = (ent.id == cmd.item_id);

endmodule

// ===== src/grpt_ctrl.sv =====
// sequencer: scans the entry ram, shifts entries on remove, builds the response
// depends on grpt_pkg, grpt_chan_if, grpt_match and assert_macros.svh
`include "assert_macros.svh"

module grpt_ctrl import grpt_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  grpt_chan_if.sink                      req,
  grpt_chan_if.source                    rsp,
  output logic                           rd_en,
  output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  input  logic [$bits(entry_t)-1:0]      rd_data,
  output logic                           wr_en,
  output logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
  output logic [$bits(entry_t)-1:0]      wr_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {IDLE, SCAN, SHIFT, DONE} state_t;

  state_t          state;
  req_t            cmd;
  logic [CW-1:0]   count;
  logic [CW-1:0]   iss;
  logic            chk_vld;
  logic [CW-1:0]   chk_idx;
  logic            hit;
  logic [AW-1:0]   hit_idx;
  entry_t          hit_entry;
  logic            rsp_vld;
  rsp_t            rsp_word;

  entry_t          rd_entry;
  match_t          hits;
  logic            sel_hit;
  logic            last_chk;
  logic            out_free;
  logic            is_full;
  logic            add_write;
  rsp_t            res_word;
  entry_t          new_entry;

  assign rd_entry = entry_t'(rd_data);

  grpt_match u_match (
    .cmd  (cmd),
    .ent  (rd_entry),
    .hits (hits)
  );

  // pick the compare that matters for this operation
  always_comb begin
    unique case (cmd.op)
      OP_ADD:        sel_hit = hits.overlap;
      OP_FIND_POINT: sel_hit = hits.cell_hit;
      OP_REMOVE:     sel_hit = hits.id_eq;
      OP_FIND_ID:    sel_hit = hits.id_eq;
    endcase
  end

  assign last_chk  = (chk_idx == count - CW'(1));
  assign out_free  = !rsp_vld || rsp.ready;
  assign is_full   = (count == CW'(MAX_ENTRIES));
  assign add_write = (state == DONE) && out_free && (cmd.op == OP_ADD) && !hit && !is_full;

  assign new_entry = '{id: cmd.item_id, row: cmd.pos_row, col: cmd.pos_col,
                       span_rows: cmd.span_rows, span_cols: cmd.span_cols};

  // ram port control; iss stays zero while idle so the first read hits slot zero
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = iss[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = chk_idx[AW-1:0] - AW'(1);
    wr_data = rd_data;
    unique case (state)
      IDLE: rd_en = req.valid;
      SCAN: rd_en = (iss < count);
      SHIFT: begin
        rd_en = (iss < count);
        wr_en = chk_vld;
      end
      DONE: begin
        if (add_write) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
          wr_data = new_entry;
        end
      end
    endcase
  end

  // response word
  always_comb begin
    res_word = '0;
    if (cmd.op == OP_ADD) begin
      if (hit) begin
        res_word.status = ST_OVERLAP;
      end else if (is_full) begin
        res_word.status = ST_FULL;
      end else begin
        res_word.status = ST_OK;
        res_word.slot   = 6'(count);
      end
    end else if (hit) begin
      res_word.status          = ST_OK;
      res_word.slot            = 6'(hit_idx);
      res_word.found_id        = hit_entry.id;
      res_word.found_col       = hit_entry.col;
      res_word.found_row       = hit_entry.row;
      res_word.found_span_cols = hit_entry.span_cols;
      res_word.found_span_rows = hit_entry.span_rows;
    end else begin
      res_word.status = ST_NOT_FOUND;
    end
  end

  assign req.ready   = (state == IDLE);
  assign rsp.valid   = rsp_vld;
  assign rsp.payload = rsp_word;

  // state, scan pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      count   <= '0;
      iss     <= '0;
      chk_vld <= 1'b0;
      hit     <= 1'b0;
      rsp_vld <= 1'b0;
    end else begin
      // a completing command reloads the output register itself
      if (rsp_vld && rsp.ready && (state != DONE)) begin
        rsp_vld <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            cmd <= req.payload;
            hit <= 1'b0;
            if (count == '0) begin
              state <= DONE;
            end else begin
              state   <= SCAN;
              iss     <= CW'(1);
              chk_vld <= 1'b1;
              chk_idx <= '0;
            end
          end
        end
        SCAN: begin
          chk_vld <= rd_en;
          chk_idx <= iss;
          if (rd_en) begin
            iss <= iss + CW'(1);
          end
          if (chk_vld && (sel_hit || last_chk)) begin
            if (sel_hit) begin
              hit       <= 1'b1;
              hit_idx   <= chk_idx[AW-1:0];
              hit_entry <= rd_entry;
            end
            if (sel_hit && (cmd.op == OP_REMOVE) && !last_chk) begin
              state <= SHIFT;
            end else begin
              state <= DONE;
            end
          end
        end
        SHIFT: begin
          chk_vld <= rd_en;
          chk_idx <= iss;
          if (rd_en) begin
            iss <= iss + CW'(1);
          end
          if (chk_vld && last_chk) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            rsp_vld  <= 1'b1;
            rsp_word <= res_word;
            if (add_write) begin
              count <= count + CW'(1);
            end else if ((cmd.op == OP_REMOVE) && hit) begin
              count <= count - CW'(1);
            end
            iss     <= '0;
            chk_vld <= 1'b0;
            state   <= IDLE;
          end
        end
      endcase
    end
  end

  `GRPT_ASSERT_RST(a_rst_clears, rst |=> (count == '0) && !rsp_vld && (state == IDLE), "reset did not clear control state")
  `GRPT_ASSERT(a_count_only_done, (state != DONE) |=> $stable(count), "entry count changed outside completion")
  `GRPT_ASSERT(a_shift_after_hit, (state == SHIFT) |-> hit && (cmd.op == OP_REMOVE), "shift without a removed entry")
  `GRPT_ASSERT(a_no_same_addr, (wr_en && rd_en) |-> (wr_addr != rd_addr), "read and write hit the same entry")
  `GRPT_ASSERT(a_one_at_a_time, (req.valid && req.ready) |=> !req.ready, "second word taken while busy")

endmodule
